FILE: sv/hcbd_pkg.sv
`timescale 1ns / 1ps

package hcbd_pkg;

  localparam int unsigned SizeDigitsMax = 4;

  localparam logic [7:0] ChCr = 8'h0d;
  localparam logic [7:0] ChLf = 8'h0a;

  localparam logic [15:0] SizeShiftLimit = 16'h0fff;

  typedef enum logic [2:0] {
    PH_SIZE     = 3'd0,
    PH_SIZE_LF  = 3'd1,
    PH_DATA     = 3'd2,
    PH_TRAIL_CR = 3'd3,
    PH_TRAIL_LF = 3'd4,
    PH_DONE     = 3'd5,
    PH_ERROR    = 3'd6
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] bytes_left;
    logic [2:0]  digit_count;
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       body_done;
    logic       syntax_error;
  } res_t;

endpackage

FILE: sv/hcbd_step.sv
`timescale 1ns / 1ps

module hcbd_step (
  input  hcbd_pkg::state_t cur_i,
  input  logic [7:0]       in_byte_i,
  output hcbd_pkg::state_t nxt_o,
  output hcbd_pkg::res_t   res_o
);

  logic       hex_ok;
  logic [3:0] hex_val;
  logic       digits_full;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i >= 8'h61 && in_byte_i <= 8'h66) begin
      hex_val = 4'(in_byte_i - 8'h57);
    end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h46) begin
      hex_val = 4'(in_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign digits_full = {1'b0, cur_i.digit_count} >= 4'(hcbd_pkg::SizeDigitsMax);

  always_comb begin
    nxt_o = cur_i;
    res_o.out_byte   = 8'd0;
    res_o.byte_valid = 1'b0;
    unique case (cur_i.phase)
      hcbd_pkg::PH_SIZE: begin
        if (hex_ok) begin
          if (digits_full || cur_i.bytes_left > hcbd_pkg::SizeShiftLimit) begin
            nxt_o.phase = hcbd_pkg::PH_ERROR;
          end else begin
            nxt_o.bytes_left  = {cur_i.bytes_left[11:0], hex_val};
            nxt_o.digit_count = cur_i.digit_count + 3'd1;
          end
        end else if (in_byte_i == hcbd_pkg::ChCr && cur_i.digit_count != 3'd0) begin
          nxt_o.phase = hcbd_pkg::PH_SIZE_LF;
        end else begin
          nxt_o.phase = hcbd_pkg::PH_ERROR;
        end
      end
      hcbd_pkg::PH_SIZE_LF: begin
        if (in_byte_i != hcbd_pkg::ChLf) begin
          nxt_o.phase = hcbd_pkg::PH_ERROR;
        end else if (cur_i.bytes_left == 16'd0) begin
          nxt_o.phase = hcbd_pkg::PH_TRAIL_CR;
        end else begin
          nxt_o.digit_count = 3'd0;
          nxt_o.phase       = hcbd_pkg::PH_DATA;
        end
      end
      hcbd_pkg::PH_DATA: begin
        res_o.out_byte   = in_byte_i;
        res_o.byte_valid = 1'b1;
        nxt_o.bytes_left = cur_i.bytes_left - 16'd1;
        if (cur_i.bytes_left == 16'd1) begin
          nxt_o.phase = hcbd_pkg::PH_TRAIL_CR;
        end
      end
      hcbd_pkg::PH_TRAIL_CR: begin
        nxt_o.phase = (in_byte_i == hcbd_pkg::ChCr) ? hcbd_pkg::PH_TRAIL_LF
                                                     : hcbd_pkg::PH_ERROR;
      end
      hcbd_pkg::PH_TRAIL_LF: begin
        if (in_byte_i != hcbd_pkg::ChLf) begin
          nxt_o.phase = hcbd_pkg::PH_ERROR;
        end else if (cur_i.digit_count != 3'd0) begin
          nxt_o.phase = hcbd_pkg::PH_DONE;
        end else begin
          nxt_o.phase       = hcbd_pkg::PH_SIZE;
          nxt_o.bytes_left  = 16'd0;
          nxt_o.digit_count = 3'd0;
        end
      end
      hcbd_pkg::PH_DONE: begin
        nxt_o.phase = hcbd_pkg::PH_DONE;
      end
      default: begin
        nxt_o.phase = hcbd_pkg::PH_ERROR;
      end
    endcase
    res_o.body_done    = nxt_o.phase == hcbd_pkg::PH_DONE;
    res_o.syntax_error = nxt_o.phase == hcbd_pkg::PH_ERROR;
  end

endmodule

FILE: sv/hcbd_out_buf.sv
`timescale 1ns / 1ps

module hcbd_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hcbd_pkg::res_t push_data_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hcbd_pkg::res_t out_data_o
);

  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;
  hcbd_pkg::res_t out_data_q, out_data_d;
  hcbd_pkg::res_t skid_data_q, skid_data_d;
  logic           pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_data_d  = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: sv/http_chunked_body_decoder.sv
`timescale 1ns / 1ps

// HTTP chunked body decoder, one byte per item.
// Input channel: in_valid_i / in_stall_o with in_byte_i, one raw body byte per item.
// Output channel: out_valid_o / out_stall_i, one result item per input item:
//   out_byte_o and byte_valid_o carry a payload byte, body_done_o and
//   syntax_error_o give the framing status after that byte.
// A result is registered in the output buffer before it is offered on the output ports.
// Throughput: one byte per cycle while in_stall_o is low; the parse state is registered on each accepted byte.
// A two-entry output buffer (result register plus skid register) lets a byte
//   be accepted while a result waits; in_stall_o rises only when both are full.
// When the receiver stalls, the held result stays unchanged on the output ports.
// Reset: the parser returns to the size line with an empty size and digit count,
//   and both output entries are emptied.
// body_done_o and syntax_error_o are sticky until reset; later bytes are
//   consumed and answered with the same status.

module http_chunked_body_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       body_done_o,
  output logic       syntax_error_o
);

  hcbd_pkg::state_t state_q, state_d;
  hcbd_pkg::res_t   step_res;
  hcbd_pkg::res_t   out_res;
  logic             buf_full;
  logic             in_accept;

  assign in_stall_o = buf_full;
  assign in_accept  = in_valid_i && !buf_full;

  hcbd_step u_step (
    .cur_i     (state_q),
    .in_byte_i (in_byte_i),
    .nxt_o     (state_d),
    .res_o     (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= hcbd_pkg::PH_SIZE;
      state_q.bytes_left  <= 16'd0;
      state_q.digit_count <= 3'd0;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  hcbd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (step_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign out_byte_o     = out_res.out_byte;
  assign byte_valid_o   = out_res.byte_valid;
  assign body_done_o    = out_res.body_done;
  assign syntax_error_o = out_res.syntax_error;

`ifndef SYNTHESIS
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == hcbd_pkg::PH_ERROR |=> state_q.phase == hcbd_pkg::PH_ERROR)
    else $error("error phase left before reset");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == hcbd_pkg::PH_DONE |=> state_q.phase == hcbd_pkg::PH_DONE)
    else $error("done phase left before reset");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> !body_done_o && !syntax_error_o)
    else $error("payload byte flagged as done or error");
`endif

endmodule
